/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_SAME(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/jzcd_pkg.sv */
// types, constants and the dead-band mapping function for the joystick calibrator
package jzcd_pkg;

  localparam int NCHAN        = 4;
  localparam int SMP_W        = 12;
  localparam int POS_W        = 8;
  localparam int SAMPLE_COUNT = 100;
  localparam int ADC_BITS     = 12;
  localparam int CNT_W        = 7;
  localparam int SUM_W        = 19;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // floor(sum / SAMPLE_COUNT) as (sum * DIV_MULT) >> DIV_SHIFT, exact for
  // every sum below SAMPLE_COUNT * 2^SMP_W
  localparam int DIV_SHIFT = 27;
  localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + MULT_W;

  // scale of 128 / 2^(ADC_BITS-1) is a right shift
  localparam int MAP_SHIFT = ADC_BITS - POS_W;
  localparam int MAP_ROUND = (2 ** MAP_SHIFT) - 1;
  localparam int EXT_W     = SMP_W + 2;

  localparam logic [SMP_W-1:0] MID_RST  = 12'd2096;
  localparam logic [SMP_W-1:0] TOL_RST  = 12'd128;
  localparam logic [SMP_W-1:0] BAND_RST = 12'd512;

  localparam logic [1:0] REG_MID  = 2'd0;
  localparam logic [1:0] REG_TOL  = 2'd1;
  localparam logic [1:0] REG_BAND = 2'd2;

  localparam logic signed [EXT_W-1:0] OUT_MAX = 14'sd127;
  localparam logic signed [EXT_W-1:0] OUT_MIN = -14'sd128;

  typedef logic [SMP_W-1:0]        sample_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [SUM_W-1:0]        sum_t;

  function automatic pos_t map_channel(sample_t v, sample_t z, sample_t db);
    logic signed [EXT_W-1:0] vs;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [EXT_W-1:0] d;
    logic signed [EXT_W-1:0] q;
    vs = $signed({2'b00, v});
    hi = $signed({2'b00, z}) + $signed({2'b00, db});
    lo = $signed({2'b00, z}) - $signed({2'b00, db});
    if (vs > hi) begin
      d = vs - hi;
    end else if (vs < lo) begin
      d = vs - lo;
    end else begin
      d = '0;
    end
    // bias negatives so the shift truncates toward zero
    if (d < 0) begin
      d = d + $signed(EXT_W'(MAP_ROUND));
    end
    q = d >>> MAP_SHIFT;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return q[POS_W-1:0];
  endfunction

endpackage

/* hdl/joystick_zero_calib_deadzone_map.sv */
// joystick zero-point calibration and dead-band mapping, four channels
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+-------------------
//  samples  | cmd, sample_left_x/y, sample_right_x/y          | sample_valid/stall
//  results  | out_left_x/y, out_right_x/y, calibrating, calib_ok | result_valid/stall
//  config   | psel, penable, pwrite, paddr, pwdata, prdata    | pready tied high
//
// one request per cycle unless a stalled result or a zero-point update holds it:
// input register, then one stage of mapping logic into the result register.
// the request that completes calibration holds off the next one while the zero
// points come from the sums through a constant multiply in the following cycle.
// rst is synchronous; after it the block is calibrating with the reference zeros.
// a stalled result holds while one more request waits in the input register.
`include "assert_macros.svh"

module joystick_zero_calib_deadzone_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              cmd,
  input  logic [jzcd_pkg::SMP_W-1:0]        sample_left_x,
  input  logic [jzcd_pkg::SMP_W-1:0]        sample_left_y,
  input  logic [jzcd_pkg::SMP_W-1:0]        sample_right_x,
  input  logic [jzcd_pkg::SMP_W-1:0]        sample_right_y,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [jzcd_pkg::POS_W-1:0] out_left_x,
  output logic signed [jzcd_pkg::POS_W-1:0] out_left_y,
  output logic signed [jzcd_pkg::POS_W-1:0] out_right_x,
  output logic signed [jzcd_pkg::POS_W-1:0] out_right_y,
  output logic                              calibrating,
  output logic                              calib_ok,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jzcd_pkg::ADDR_W-1:0]       paddr,
  input  logic [jzcd_pkg::DATA_W-1:0]       pwdata,
  output logic [jzcd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int N = jzcd_pkg::NCHAN;

  // configuration registers
  jzcd_pkg::sample_t mid_reference;
  jzcd_pkg::sample_t cal_tolerance;
  jzcd_pkg::sample_t dead_band;

  // calibration state
  jzcd_pkg::sample_t [N-1:0] zero_point;
  jzcd_pkg::sum_t    [N-1:0] calib_sum;
  logic [jzcd_pkg::CNT_W-1:0] calib_count;
  logic in_calibration;
  logic calib_good;
  logic div_pend;

  // input register
  logic                      s1_valid;
  logic                      s1_cmd;
  jzcd_pkg::sample_t [N-1:0] s1_smp;

  // result register
  jzcd_pkg::pos_t [N-1:0] res_pos;

  logic s1_go;
  logic sample_take;
  logic cfg_wr;

  jzcd_pkg::sum_t [N-1:0]      calib_sum_next;
  logic [jzcd_pkg::CNT_W-1:0]  calib_count_next;
  logic                        in_calibration_next;
  logic                        calib_good_next;
  logic                        cal_abort;
  logic                        cal_done;
  jzcd_pkg::pos_t [N-1:0]      pos_next;
  jzcd_pkg::sample_t [N-1:0]   zero_quot;
  logic signed [jzcd_pkg::EXT_W-1:0] tol_lo;
  logic signed [jzcd_pkg::EXT_W-1:0] tol_hi;
  logic [N-1:0]                out_of_band;
  logic [jzcd_pkg::PROD_W-1:0] prod [N];

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      jzcd_pkg::REG_MID:  prdata = jzcd_pkg::DATA_W'(mid_reference);
      jzcd_pkg::REG_TOL:  prdata = jzcd_pkg::DATA_W'(cal_tolerance);
      jzcd_pkg::REG_BAND: prdata = jzcd_pkg::DATA_W'(dead_band);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_reference <= jzcd_pkg::MID_RST;
      cal_tolerance <= jzcd_pkg::TOL_RST;
      dead_band     <= jzcd_pkg::BAND_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        jzcd_pkg::REG_MID:  mid_reference <= pwdata[jzcd_pkg::SMP_W-1:0];
        jzcd_pkg::REG_TOL:  cal_tolerance <= pwdata[jzcd_pkg::SMP_W-1:0];
        jzcd_pkg::REG_BAND: dead_band     <= pwdata[jzcd_pkg::SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  // the input register only moves on when the result register has room and
  // no zero-point update is still settling
  assign s1_go        = s1_valid && !div_pend && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !s1_go;
  assign sample_take  = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_cmd    <= cmd;
      s1_smp[0] <= sample_left_x;
      s1_smp[1] <= sample_left_y;
      s1_smp[2] <= sample_right_x;
      s1_smp[3] <= sample_right_y;
    end
  end

  // ---------------------------------------------------------------- per-request logic
  assign tol_lo = $signed({2'b00, mid_reference}) - $signed({2'b00, cal_tolerance});
  assign tol_hi = $signed({2'b00, mid_reference}) + $signed({2'b00, cal_tolerance});
  assign calib_count_next = calib_count + 1'b1;
  assign cal_done = calib_count_next >= jzcd_pkg::CNT_W'(jzcd_pkg::SAMPLE_COUNT);
  assign cal_abort = |out_of_band;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      out_of_band[i] = ($signed({2'b00, s1_smp[i]}) > tol_hi) ||
                       ($signed({2'b00, s1_smp[i]}) < tol_lo);
      calib_sum_next[i] = calib_sum[i] + jzcd_pkg::SUM_W'(s1_smp[i]);
      pos_next[i] = jzcd_pkg::map_channel(s1_smp[i], zero_point[i], dead_band);
      prod[i] = jzcd_pkg::PROD_W'(calib_sum[i]) * jzcd_pkg::PROD_W'(jzcd_pkg::DIV_MULT);
      zero_quot[i] = prod[i][jzcd_pkg::DIV_SHIFT +: jzcd_pkg::SMP_W];
    end
  end

  always_comb begin
    in_calibration_next = in_calibration;
    calib_good_next     = calib_good;
    if (s1_cmd) begin
      in_calibration_next = 1'b1;
    end else if (in_calibration) begin
      if (cal_abort) begin
        in_calibration_next = 1'b0;
        calib_good_next     = 1'b0;
      end else if (cal_done) begin
        in_calibration_next = 1'b0;
        calib_good_next     = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_calibration <= 1'b1;
      calib_good     <= 1'b0;
      calib_count    <= '0;
      div_pend       <= 1'b0;
      for (int i = 0; i < N; i++) begin
        calib_sum[i]  <= '0;
        zero_point[i] <= jzcd_pkg::MID_RST;
      end
    end else begin
      div_pend <= 1'b0;
      if (div_pend) begin
        for (int i = 0; i < N; i++) begin
          zero_point[i] <= zero_quot[i];
        end
      end
      if (s1_go) begin
        in_calibration <= in_calibration_next;
        calib_good     <= calib_good_next;
        if (s1_cmd) begin
          calib_count <= '0;
          for (int i = 0; i < N; i++) begin
            calib_sum[i] <= '0;
          end
        end else if (in_calibration) begin
          calib_count <= calib_count_next;
          for (int i = 0; i < N; i++) begin
            calib_sum[i] <= calib_sum_next[i];
          end
          if (cal_abort) begin
            for (int i = 0; i < N; i++) begin
              zero_point[i] <= mid_reference;
            end
          end else if (cal_done) begin
            // quotients are taken from the summed registers next cycle
            div_pend <= 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      calibrating <= in_calibration_next;
      calib_ok    <= calib_good_next;
      for (int i = 0; i < N; i++) begin
        res_pos[i] <= (s1_cmd || in_calibration) ? '0 : pos_next[i];
      end
    end
  end

  assign out_left_x  = res_pos[0];
  assign out_left_y  = res_pos[1];
  assign out_right_x = res_pos[2];
  assign out_right_y = res_pos[3];

  // ---------------------------------------------------------------- checks
  `CHK_NEXT(a_div_one_cycle, clk, rst, div_pend, !div_pend)
  `CHK_SAME(a_hold_during_div, clk, rst, div_pend, !s1_go)
  `CHK_SAME(a_count_in_range, clk, rst, in_calibration, calib_count < jzcd_pkg::CNT_W'(jzcd_pkg::SAMPLE_COUNT))
  `CHK_SAME(a_cal_zero_out, clk, rst, result_valid && calibrating, (out_left_x == '0) && (out_left_y == '0) && (out_right_x == '0) && (out_right_y == '0))
  `CHK_NEXT(a_done_sets_good, clk, rst, s1_go && !s1_cmd && in_calibration && !cal_abort && cal_done, calib_good && !in_calibration)

endmodule
